@@ hdl/station_association_table_defines.svh @@
// Assertion macros used by the top level of the station association table.
`ifndef STATION_ASSOCIATION_TABLE_DEFINES_SVH
`define STATION_ASSOCIATION_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sat_pkg.sv @@
// Package with sizes, codes, types and helper functions of the station table.
`default_nettype none
package sat_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int MAC_W         = 48;
  localparam int STATE_W       = 2;
  localparam int ID_W          = 4;
  localparam int SLOT_W        = 3;

  // Action codes of an input item.
  localparam logic ACT_LOOKUP   = 1'b0;
  localparam logic ACT_REGISTER = 1'b1;

  // Client state that marks a free entry.
  localparam logic [STATE_W-1:0] ST_DISCONNECTED = '0;

  // Result of the parallel search over all entries.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } search_t;

  // One write into the table.
  typedef struct packed {
    logic               we;
    logic               alloc;
    logic [IDX_W-1:0]   idx;
    logic [MAC_W-1:0]   mac;
    logic [STATE_W-1:0] status;
    logic [ID_W-1:0]    id;
  } tbl_wr_t;

  // Slot number as reported: the low bits of the entry index.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W+ID_W-1:0] ext;
    ext = {{ID_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

  // Association ID given to a new entry: index plus one, kept to the ID width.
  function automatic logic [ID_W-1:0] id_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W+ID_W-1:0] ext;
    ext = {{ID_W{1'b0}}, idx} + (IDX_W + ID_W)'(1);
    return ext[ID_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/sat_search.sv @@
// Parallel address match and first-free search over all table entries.
`default_nettype none
module sat_search
  import sat_pkg::*;
(
  input  wire logic [TABLE_ENTRIES-1:0][MAC_W-1:0]   ent_addr,
  input  wire logic [TABLE_ENTRIES-1:0][STATE_W-1:0] ent_status,
  input  wire logic [MAC_W-1:0]                      mac,
  output search_t                                    srch
);

  // Walk from the top down so that the lowest matching entry wins.
  always_comb begin
    srch = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (ent_addr[i] == mac) begin
        srch.hit     = 1'b1;
        srch.hit_idx = IDX_W'(i);
      end
      if (ent_status[i] == ST_DISCONNECTED) begin
        srch.free     = 1'b1;
        srch.free_idx = IDX_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/sat_table.sv @@
// Entry storage: address, client state and association ID of every station.
`default_nettype none
module sat_table
  import sat_pkg::*;
(
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire tbl_wr_t                               wr,
  output logic [TABLE_ENTRIES-1:0][MAC_W-1:0]        ent_addr,
  output logic [TABLE_ENTRIES-1:0][STATE_W-1:0]      ent_status,
  output logic [TABLE_ENTRIES-1:0][ID_W-1:0]         ent_id
);

  logic [TABLE_ENTRIES-1:0][MAC_W-1:0]   addr_r;
  logic [TABLE_ENTRIES-1:0][STATE_W-1:0] status_r;
  logic [TABLE_ENTRIES-1:0][ID_W-1:0]    id_r;

  // A state write touches one entry; a new entry also takes address and ID.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      status_r <= '0;
      id_r     <= '0;
    end else if (wr.we) begin
      status_r[wr.idx] <= wr.status;
      if (wr.alloc) begin
        addr_r[wr.idx] <= wr.mac;
        id_r[wr.idx]   <= wr.id;
      end
    end
  end

  assign ent_addr   = addr_r;
  assign ent_status = status_r;
  assign ent_id     = id_r;

endmodule
`default_nettype wire

@@ hdl/station_association_table.sv @@
// Top level of the station association table: item registers, decision logic and checks.
//
// The block keeps a small table of stations for an access point. Each input item
// carries an action, a 48-bit station address and a client state. A lookup item
// reports whether the address is stored, in which slot, and that entry's ID and
// state. A register item updates the state of a stored address, or else takes the
// lowest disconnected entry and gives it association ID slot+1; with no free entry
// it reports a miss and leaves the table alone.
// Both channels use valid/ready. An accepted item sits in the input register,
// where the match and the table write happen, and its result is shown from the
// output register, one item per cycle sustained while the receiver keeps up.
// The table write and the result load share the same edge, so the next item
// always sees the updated table.
// Reset clears every entry to address zero, disconnected, ID zero, and empties
// both registers. When the receiver stalls, the result holds; one more item
// may wait in the input register, and then in_ready drops until the result goes.
`default_nettype none
`include "station_association_table_defines.svh"
module station_association_table
  import sat_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_action,
  input  wire logic [MAC_W-1:0]   in_station_mac,
  input  wire logic [STATE_W-1:0] in_new_state,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_hit,
  output logic [SLOT_W-1:0]       out_slot,
  output logic [ID_W-1:0]         out_assoc_id,
  output logic [STATE_W-1:0]      out_entry_state
);

  logic               s_vld_r;
  logic               s_action_r;
  logic [MAC_W-1:0]   s_mac_r;
  logic [STATE_W-1:0] s_state_r;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               o_hit_r, o_hit_nxt;
  logic [SLOT_W-1:0]  o_slot_r, o_slot_nxt;
  logic [ID_W-1:0]    o_id_r, o_id_nxt;
  logic [STATE_W-1:0] o_state_r, o_state_nxt;

  logic                                  advance;
  logic                                  is_reg;
  logic                                  alloc;
  logic                                  res_hit;
  logic [IDX_W-1:0]                      idx;
  search_t                               srch;
  tbl_wr_t                               wr;
  logic [TABLE_ENTRIES-1:0][MAC_W-1:0]   ent_addr;
  logic [TABLE_ENTRIES-1:0][STATE_W-1:0] ent_status;
  logic [TABLE_ENTRIES-1:0][ID_W-1:0]    ent_id;

  // The held item moves on when the result register is empty or being emptied.
  assign advance  = s_vld_r && (!out_valid_r || out_ready);
  assign in_ready = !s_vld_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_ready) begin
      s_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_action_r <= in_action;
      s_mac_r    <= in_station_mac;
      s_state_r  <= in_new_state;
    end
  end

  sat_search u_search (
    .ent_addr   (ent_addr),
    .ent_status (ent_status),
    .mac        (s_mac_r),
    .srch       (srch)
  );

  sat_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .ent_addr   (ent_addr),
    .ent_status (ent_status),
    .ent_id     (ent_id)
  );

  // Decide between a match, a new entry and a miss, and build the write.
  always_comb begin
    is_reg  = (s_action_r == ACT_REGISTER);
    alloc   = is_reg && !srch.hit && srch.free;
    res_hit = srch.hit || alloc;
    idx     = srch.hit ? srch.hit_idx : srch.free_idx;

    wr        = '0;
    wr.we     = advance && is_reg && res_hit;
    wr.alloc  = alloc;
    wr.idx    = idx;
    wr.mac    = s_mac_r;
    wr.status = s_state_r;
    wr.id     = id_of(idx);
  end

  // Result register next values.
  always_comb begin
    out_valid_nxt = out_valid_r;
    o_hit_nxt     = o_hit_r;
    o_slot_nxt    = o_slot_r;
    o_id_nxt      = o_id_r;
    o_state_nxt   = o_state_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      o_hit_nxt     = res_hit;
      o_slot_nxt    = '0;
      o_id_nxt      = '0;
      o_state_nxt   = '0;
      if (res_hit) begin
        o_slot_nxt  = slot_of(idx);
        o_id_nxt    = alloc ? id_of(idx) : ent_id[idx];
        o_state_nxt = is_reg ? s_state_r : ent_status[idx];
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_hit_r   <= o_hit_nxt;
    o_slot_r  <= o_slot_nxt;
    o_id_r    <= o_id_nxt;
    o_state_r <= o_state_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = o_hit_r;
  assign out_slot        = o_slot_r;
  assign out_assoc_id    = o_id_r;
  assign out_entry_state = o_state_r;

  // The table only changes when an item moves into the result register.
  `SAT_ASSERT_NOW(a_write_on_advance, wr.we, advance, "table written without advancing item")
  // A full pipeline with a stalled receiver must refuse new items.
  `SAT_ASSERT_NOW(a_stall_blocks_input, s_vld_r && out_valid_r && !out_ready, !in_ready,
                  "input accepted while pipeline is blocked")
  // A miss reports all-zero fields.
  `SAT_ASSERT_NOW(a_miss_zero, out_valid && !out_hit,
                  out_slot == '0 && out_assoc_id == '0 && out_entry_state == '0,
                  "miss result carries nonzero fields")
  // A newly allocated entry holds the address of the item that created it.
  `SAT_ASSERT_NEXT(a_alloc_stores_mac, wr.we && wr.alloc,
                   ent_addr[$past(wr.idx)] == $past(wr.mac),
                   "allocated entry does not hold the new address")

endmodule
`default_nettype wire

@@ tb/sv/station_table_checker.sv @@
// Checker for the station association table: mirrors the table and compares every result.
module station_table_checker
  import sat_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_action,
  input  logic [MAC_W-1:0]   in_station_mac,
  input  logic [STATE_W-1:0] in_new_state,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_hit,
  input  logic [SLOT_W-1:0]  out_slot,
  input  logic [ID_W-1:0]    out_assoc_id,
  input  logic [STATE_W-1:0] out_entry_state,
  output int                 fail_count,
  output int                 pending_results,
  output int                 results_seen,
  output int                 hits_seen,
  output int                 full_refusals
);

  // One result item as the block should report it.
  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    assoc_id;
    logic [STATE_W-1:0] entry_state;
  } station_result_t;

  // Shadow copy of the station table.
  logic [MAC_W-1:0]   shadow_mac   [TABLE_ENTRIES];
  logic [STATE_W-1:0] shadow_state [TABLE_ENTRIES];
  logic [ID_W-1:0]    shadow_id    [TABLE_ENTRIES];

  // Results still owed by the block, oldest first.
  station_result_t expected_results[$];

  // Applies one item to the shadow table and works out its result.
  task automatic apply_station_item(input logic act, input logic [MAC_W-1:0] mac,
                                    input logic [STATE_W-1:0] st,
                                    output station_result_t res);
    int found;
    int spare;
    found = -1;
    spare = -1;
    // The lowest matching slot wins, whatever its state.
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (found < 0 && shadow_mac[i] == mac) found = i;
    end
    // A new station takes the lowest disconnected entry, if there is one.
    if (act == ACT_REGISTER && found < 0) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (spare < 0 && shadow_state[i] == ST_DISCONNECTED) spare = i;
      end
      if (spare >= 0) begin
        shadow_mac[spare] = mac;
        shadow_id[spare]  = ID_W'(spare + 1);
        found = spare;
      end else begin
        full_refusals++;
      end
    end
    if (act == ACT_REGISTER && found >= 0) shadow_state[found] = st;
    res = '0;
    if (found >= 0) begin
      res.hit         = 1'b1;
      res.slot        = SLOT_W'(found);
      res.assoc_id    = shadow_id[found];
      res.entry_state = shadow_state[found];
      hits_seen++;
    end
  endtask

  // Compare results against the oldest expectation, then predict new items.
  always @(posedge clk) begin
    station_result_t want;
    station_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        shadow_mac[i]   = '0;
        shadow_state[i] = ST_DISCONNECTED;
        shadow_id[i]    = '0;
      end
      expected_results.delete();
      pending_results = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("Result item arrived with no item outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_hit !== want.hit) begin
            $error("out_hit: expected %0d, got %0d", want.hit, out_hit);
            fail_count++;
          end
          if (out_slot !== want.slot) begin
            $error("out_slot: expected %0d, got %0d", want.slot, out_slot);
            fail_count++;
          end
          if (out_assoc_id !== want.assoc_id) begin
            $error("out_assoc_id: expected %0d, got %0d", want.assoc_id, out_assoc_id);
            fail_count++;
          end
          if (out_entry_state !== want.entry_state) begin
            $error("out_entry_state: expected %0d, got %0d", want.entry_state,
                   out_entry_state);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_station_item(in_action, in_station_mac, in_new_state, got);
        expected_results.push_back(got);
      end
      pending_results = expected_results.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the station association table: clock, reset, stimulus and verdict.
module tb_top;
  import sat_pkg::*;

  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int PHASES           = 10;
  localparam int ITEMS_PER_PHASE  = 105;
  localparam int POOL_DEPTH       = 16;
  localparam int TAIL_CYCLES      = 10;

  // Client states other than disconnected.
  localparam logic [STATE_W-1:0] ST_AUTHENTICATED = 2'd1;
  localparam logic [STATE_W-1:0] ST_ASSOCIATED    = 2'd2;
  localparam logic [STATE_W-1:0] ST_AUTHORIZED    = 2'd3;

  // Station addresses for the directed part.
  localparam logic [MAC_W-1:0] MAC_ZERO     = '0;
  localparam logic [MAC_W-1:0] MAC_ALL_ONES = '1;
  localparam logic [MAC_W-1:0] STA_A = 48'h02_11_22_33_44_55;
  localparam logic [MAC_W-1:0] STA_B = 48'h02_aa_bb_cc_dd_01;
  localparam logic [MAC_W-1:0] STA_C = 48'h80_00_00_00_00_01;
  localparam logic [MAC_W-1:0] STA_D = 48'h5c_cf_7f_00_10_20;
  localparam logic [MAC_W-1:0] STA_E = 48'hfe_ff_ff_ff_ff_fe;
  localparam logic [MAC_W-1:0] STA_F = 48'h00_00_00_00_00_01;
  localparam logic [MAC_W-1:0] STA_G = 48'h7f_ff_ff_ff_ff_ff;
  localparam logic [MAC_W-1:0] STA_H = 48'h3c_a5_5a_c3_0f_f0;
  localparam logic [MAC_W-1:0] STA_J = 48'hc0_ff_ee_12_34_56;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_action;
  logic [MAC_W-1:0]   in_station_mac;
  logic [STATE_W-1:0] in_new_state;
  logic               out_valid;
  logic               out_ready;
  logic               out_hit;
  logic [SLOT_W-1:0]  out_slot;
  logic [ID_W-1:0]    out_assoc_id;
  logic [STATE_W-1:0] out_entry_state;

  int fail_count;
  int pending_results;
  int results_seen;
  int hits_seen;
  int full_refusals;
  int items_sent;
  int lookups_sent;
  int idle_cycles;

  bit sender_gaps;
  bit receiver_gaps;
  bit long_hold_req;
  int pool_used;

  logic [MAC_W-1:0] mac_pool [POOL_DEPTH];
  logic [MAC_W-1:0] stray_macs[$];

  station_association_table u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_station_mac  (in_station_mac),
    .in_new_state    (in_new_state),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_slot        (out_slot),
    .out_assoc_id    (out_assoc_id),
    .out_entry_state (out_entry_state)
  );

  station_table_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_station_mac  (in_station_mac),
    .in_new_state    (in_new_state),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_slot        (out_slot),
    .out_assoc_id    (out_assoc_id),
    .out_entry_state (out_entry_state),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_seen    (results_seen),
    .hits_seen       (hits_seen),
    .full_refusals   (full_refusals)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one item after an optional gap and waits until it is taken.
  task automatic send_item(input logic act, input logic [MAC_W-1:0] mac,
                           input logic [STATE_W-1:0] st);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_station_mac <= mac;
    in_new_state   <= st;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (act == ACT_LOOKUP) lookups_sent++;
  endtask

  // Random item: mostly addresses from the pool so that entries are hit and reused.
  task automatic send_random_item();
    logic             act;
    logic [MAC_W-1:0] mac;
    logic [63:0]      wide;
    act  = $urandom_range(0, 1) ? ACT_REGISTER : ACT_LOOKUP;
    wide = {$urandom, $urandom};
    mac  = mac_pool[$urandom_range(0, pool_used - 1)];
    if ((act == ACT_LOOKUP && $urandom_range(0, 3) == 0) || $urandom_range(0, 19) == 0) begin
      mac = wide[MAC_W-1:0];
      // Remember stray stations so they can be released later.
      if (act == ACT_REGISTER) stray_macs.push_back(mac);
    end
    send_item(act, mac, STATE_W'($urandom_range(0, 3)));
  endtask

  // Holds the sender back until every outstanding result has come.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main stimulus and verdict.
  initial begin
    logic [63:0] wide;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_LOOKUP;
    in_station_mac = '0;
    in_new_state   = ST_DISCONNECTED;
    idle_cycles    = 0;
    sender_gaps    = 1'b0;
    receiver_gaps  = 1'b1;
    mac_pool[0] = MAC_ZERO;
    mac_pool[1] = MAC_ALL_ONES;
    for (int i = 2; i < POOL_DEPTH; i++) begin
      wide = {$urandom, $urandom};
      mac_pool[i] = wide[MAC_W-1:0];
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: cleared entries, reuse of free entries, a full table.
    send_item(ACT_LOOKUP,   MAC_ZERO,     ST_AUTHORIZED);
    send_item(ACT_LOOKUP,   MAC_ALL_ONES, ST_DISCONNECTED);
    send_item(ACT_REGISTER, MAC_ZERO,     ST_ASSOCIATED);
    send_item(ACT_REGISTER, STA_A,        ST_AUTHENTICATED);
    // A new station stored as disconnected leaves its entry free.
    send_item(ACT_REGISTER, STA_B,        ST_DISCONNECTED);
    send_item(ACT_REGISTER, STA_C,        ST_AUTHORIZED);
    send_item(ACT_LOOKUP,   STA_B,        ST_DISCONNECTED);
    send_item(ACT_LOOKUP,   STA_C,        ST_DISCONNECTED);
    // A known station set to disconnected keeps its address and ID.
    send_item(ACT_REGISTER, STA_A,        ST_DISCONNECTED);
    send_item(ACT_LOOKUP,   STA_A,        ST_AUTHENTICATED);
    send_item(ACT_REGISTER, MAC_ALL_ONES, ST_AUTHORIZED);
    send_item(ACT_REGISTER, STA_D,        ST_AUTHENTICATED);
    send_item(ACT_REGISTER, STA_E,        ST_ASSOCIATED);
    send_item(ACT_REGISTER, STA_F,        ST_AUTHORIZED);
    send_item(ACT_REGISTER, STA_G,        ST_AUTHENTICATED);
    send_item(ACT_REGISTER, STA_H,        ST_ASSOCIATED);
    // Table is now full.
    send_item(ACT_REGISTER, STA_J,        ST_AUTHENTICATED);
    send_item(ACT_LOOKUP,   STA_J,        ST_AUTHORIZED);
    send_item(ACT_LOOKUP,   MAC_ZERO,     ST_DISCONNECTED);
    send_item(ACT_REGISTER, MAC_ZERO,     ST_DISCONNECTED);
    send_item(ACT_REGISTER, STA_J,        ST_AUTHORIZED);
    send_item(ACT_LOOKUP,   MAC_ZERO,     ST_DISCONNECTED);
    send_item(ACT_LOOKUP,   STA_H,        ST_DISCONNECTED);

    // Random phases with varying idling and pool size.
    for (int phase = 0; phase < PHASES; phase++) begin
      sender_gaps   = (phase % 3 != 0);
      receiver_gaps = (phase % 4 != 1);
      pool_used     = $urandom_range(6, POOL_DEPTH);
      // Release stray stations so the table does not clog for good.
      while (stray_macs.size() != 0) begin
        send_item(ACT_REGISTER, stray_macs.pop_front(), ST_DISCONNECTED);
      end
      repeat (ITEMS_PER_PHASE) send_random_item();
      if (phase == 3) begin
        // Long receiver hold-off while items keep coming: the block must back up.
        wait_drained();
        sender_gaps   = 1'b0;
        long_hold_req = 1'b1;
        repeat (12) send_random_item();
      end
      if (phase == 6) wait_drained();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d station items (%0d lookups, %0d registers).",
             items_sent, lookups_sent, items_sent - lookups_sent);
    $display("Checked %0d results: %0d hits, %0d registers refused on a full table.",
             results_seen, hits_seen, full_refusals);
    if (fail_count == 0 && pending_results == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
